// ----- rtl/core/ycc2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// ycc2rgb_pkg
// Types and constants for the YCbCr to RGB color matrix unit.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 11;
    localparam int OFFS_W  = 9;
    localparam int TERM_W  = 10;
    localparam int PROD_W  = COEF_W + TERM_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int OFFSETS_W = 3 * OFFS_W;
    localparam int FRAC_W  = 8;

    typedef enum logic [2:0] {
        REG_RED_ROW   = 3'd0,
        REG_GREEN_ROW = 3'd1,
        REG_BLUE_ROW  = 3'd2,
        REG_OFFSETS   = 3'd3,
        REG_ENABLE    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } ycc_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0]     red_row_coefs;
        logic [ROW_W-1:0]     green_row_coefs;
        logic [ROW_W-1:0]     blue_row_coefs;
        logic [OFFSETS_W-1:0] input_offsets;
        logic                 convert_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] y;
        logic signed [TERM_W-1:0] cb;
        logic signed [TERM_W-1:0] cr;
    } terms_t;

    typedef struct packed {
        logic en2;
        logic en3;
    } row_ctrl_t;

endpackage

// ----- rtl/core/ycc2rgb_regs.sv -----
// ----------------------------------------------------------------------------
// ycc2rgb_regs
// APB-style register file that holds the matrix, offsets and enable.
// ----------------------------------------------------------------------------
module ycc2rgb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ycc2rgb_pkg::ADDR_W-1:0] paddr,
    input  logic [ycc2rgb_pkg::DATA_W-1:0] pwdata,
    output logic [ycc2rgb_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    output ycc2rgb_pkg::cfg_t             cfg
);
    import ycc2rgb_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RED_ROW:   cfg_next.red_row_coefs   = pwdata[ROW_W-1:0];
                REG_GREEN_ROW: cfg_next.green_row_coefs = pwdata[ROW_W-1:0];
                REG_BLUE_ROW:  cfg_next.blue_row_coefs  = pwdata[ROW_W-1:0];
                REG_OFFSETS:   cfg_next.input_offsets   = pwdata[OFFSETS_W-1:0];
                REG_ENABLE:    cfg_next.convert_enable  = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RED_ROW:   prdata = DATA_W'(cfg_reg.red_row_coefs);
            REG_GREEN_ROW: prdata = DATA_W'(cfg_reg.green_row_coefs);
            REG_BLUE_ROW:  prdata = DATA_W'(cfg_reg.blue_row_coefs);
            REG_OFFSETS:   prdata = DATA_W'(cfg_reg.input_offsets);
            REG_ENABLE:    prdata = DATA_W'(cfg_reg.convert_enable);
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/ycc2rgb_row.sv -----
// ----------------------------------------------------------------------------
// ycc2rgb_row
// One matrix row: three registered products, a registered rounded sum,
// and the clamp to 0..255.
// ----------------------------------------------------------------------------
module ycc2rgb_row
(
    input  logic                          clk,
    input  ycc2rgb_pkg::row_ctrl_t        ctrl,
    input  logic [ycc2rgb_pkg::ROW_W-1:0] coefs,
    input  ycc2rgb_pkg::terms_t           terms,
    output logic [ycc2rgb_pkg::PIX_W-1:0] result
);
    import ycc2rgb_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (FRAC_W - 1));

    logic signed [COEF_W-1:0] w_y;
    logic signed [COEF_W-1:0] w_cb;
    logic signed [COEF_W-1:0] w_cr;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_cb_reg;
    logic signed [PROD_W-1:0] prod_cr_reg;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] prod_cb_next;
    logic signed [PROD_W-1:0] prod_cr_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    assign w_y  = $signed(coefs[COEF_W-1:0]);
    assign w_cb = $signed(coefs[2*COEF_W-1:COEF_W]);
    assign w_cr = $signed(coefs[3*COEF_W-1:2*COEF_W]);

    assign prod_y_next  = w_y  * terms.y;
    assign prod_cb_next = w_cb * terms.cb;
    assign prod_cr_next = w_cr * terms.cr;

    assign sum_next = SUM_W'(prod_y_reg) + SUM_W'(prod_cb_reg) + SUM_W'(prod_cr_reg)
                      + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            prod_y_reg  <= prod_y_next;
            prod_cb_reg <= prod_cb_next;
            prod_cr_reg <= prod_cr_next;
        end
        if (ctrl.en3)
        begin
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        priority if (sum_reg[SUM_W-1])
        begin
            result = '0;
        end
        else if (|sum_reg[SUM_W-2:FRAC_W+PIX_W])
        begin
            result = '1;
        end
        else
        begin
            result = sum_reg[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

endmodule

// ----- rtl/core/ycc2rgb_datapath.sv -----
// ----------------------------------------------------------------------------
// ycc2rgb_datapath
// Four-stage pixel pipeline: offset add, multiply, sum, clamp and select.
// Each stage moves when the stage ahead of it is empty or moving.
// ----------------------------------------------------------------------------
module ycc2rgb_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ycc2rgb_pkg::cfg_t       cfg,
    input  logic                    ycc_valid,
    output logic                    ycc_stall,
    input  ycc2rgb_pkg::ycc_pixel_t ycc,
    output logic                    rgb_valid,
    input  logic                    rgb_stall,
    output ycc2rgb_pkg::rgb_pixel_t rgb
);
    import ycc2rgb_pkg::*;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       en1, en2, en3, en4;
    logic       conv1_reg, conv2_reg, conv3_reg;
    ycc_pixel_t pix1_reg, pix2_reg, pix3_reg;
    terms_t     terms_reg;
    terms_t     terms_next;
    rgb_pixel_t rgb_reg;
    rgb_pixel_t rgb_next;
    rgb_pixel_t conv_rgb;
    row_ctrl_t  row_ctrl;

    assign en4 = !v4_reg || !rgb_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign ycc_stall = !en1;
    assign row_ctrl  = '{en2: en2, en3: en3};

    assign terms_next.y  = $signed({2'b00, ycc.luma})
                         + $signed({cfg.input_offsets[OFFS_W-1], 
                                    cfg.input_offsets[OFFS_W-1:0]});
    assign terms_next.cb = $signed({2'b00, ycc.chroma_blue})
                         + $signed({cfg.input_offsets[2*OFFS_W-1],
                                    cfg.input_offsets[2*OFFS_W-1:OFFS_W]});
    assign terms_next.cr = $signed({2'b00, ycc.chroma_red})
                         + $signed({cfg.input_offsets[3*OFFS_W-1],
                                    cfg.input_offsets[3*OFFS_W-1:2*OFFS_W]});

    ycc2rgb_row u_row_red
    (
        .clk    (clk),
        .ctrl   (row_ctrl),
        .coefs  (cfg.red_row_coefs),
        .terms  (terms_reg),
        .result (conv_rgb.red)
    );

    ycc2rgb_row u_row_green
    (
        .clk    (clk),
        .ctrl   (row_ctrl),
        .coefs  (cfg.green_row_coefs),
        .terms  (terms_reg),
        .result (conv_rgb.green)
    );

    ycc2rgb_row u_row_blue
    (
        .clk    (clk),
        .ctrl   (row_ctrl),
        .coefs  (cfg.blue_row_coefs),
        .terms  (terms_reg),
        .result (conv_rgb.blue)
    );

    always_comb
    begin
        if (conv3_reg)
        begin
            rgb_next = conv_rgb;
        end
        else
        begin
            rgb_next.red   = pix3_reg.luma;
            rgb_next.green = pix3_reg.chroma_blue;
            rgb_next.blue  = pix3_reg.chroma_red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= ycc_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            terms_reg <= terms_next;
            pix1_reg  <= ycc;
            conv1_reg <= cfg.convert_enable;
        end
        if (en2)
        begin
            pix2_reg  <= pix1_reg;
            conv2_reg <= conv1_reg;
        end
        if (en3)
        begin
            pix3_reg  <= pix2_reg;
            conv3_reg <= conv2_reg;
        end
        if (en4)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = v4_reg;
    assign rgb       = rgb_reg;

endmodule

// ----- rtl/core/ycbcr_to_rgb_color_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_color_matrix_unit
// Converts one YCbCr pixel per cycle, while not stalled, to RGB through a 3x3
// programmable matrix with input offsets, or passes it through when disabled.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   ycc       in         ycc_valid/stall     luma, chroma_blue, chroma_red
//   rgb       out        rgb_valid/stall     red, green, blue
//   apb       in/out     psel/penable/pready 64-bit registers at 8*index
//
// An accepted item enters the offset stage and moves on through the
// multiply, sum and clamp stages to the output register, where it can leave;
// one item enters every cycle while ycc is not stalled.
// Reset clears all valid bits and the register file; no clearing pass is needed.
// A stall on rgb holds the output register, and bubbles ahead of it still
// fill, so ycc stalls only once all four stages hold items.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_color_matrix_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ycc2rgb_pkg::ADDR_W-1:0] paddr,
    input  logic [ycc2rgb_pkg::DATA_W-1:0] pwdata,
    output logic [ycc2rgb_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           ycc_valid,
    output logic                           ycc_stall,
    input  ycc2rgb_pkg::ycc_pixel_t        ycc,
    output logic                           rgb_valid,
    input  logic                           rgb_stall,
    output ycc2rgb_pkg::rgb_pixel_t        rgb
);
    import ycc2rgb_pkg::*;

    cfg_t cfg;

    ycc2rgb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ycc2rgb_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ycc_valid (ycc_valid),
        .ycc_stall (ycc_stall),
        .ycc       (ycc),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

endmodule

// ----- rtl/core/ycc2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// ycc2rgb_checker
// Port-level checks of the color matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module ycc2rgb_checker
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ycc_valid,
    input  logic                    ycc_stall,
    input  logic                    rgb_valid,
    input  logic                    rgb_stall,
    input  ycc2rgb_pkg::rgb_pixel_t rgb
);
    import ycc2rgb_pkg::*;

    // A held result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> $stable(rgb))
        else $error("rgb payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid)
        else $error("rgb item dropped while stalled");

    // The input side stalls only when the pipeline is full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        ycc_stall |-> rgb_valid && rgb_stall)
        else $error("ycc stalled while the output could move");

    // An accepted item is checked to be followed by rgb_valid at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        ycc_valid && !ycc_stall |-> ##4 rgb_valid)
        else $error("accepted item did not reach the output");

endmodule

bind ycbcr_to_rgb_color_matrix_unit ycc2rgb_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .ycc_valid (ycc_valid),
    .ycc_stall (ycc_stall),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
);
